// ----- rtl/core/qmn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion multiply and normalise package
// Shared constants, operation codes, product table and pipeline sideband type.
// ----------------------------------------------------------------------------
package qmn_pkg;

  localparam int FRAC_BITS_DEF  = 14;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int NORM_BITS      = 30;

  typedef enum logic {
    OP_MUL_NORM = 1'b0,
    OP_NORM_A   = 1'b1
  } op_t;

  // Hamilton product: for each result component, four terms of a index,
  // b index and whether the term is subtracted.
  localparam logic [1:0] PROD_A [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };
  localparam logic [1:0] PROD_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic PROD_SUB [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic                       zero;
    logic [3:0]                 neg;
    logic [3:0][NORM_BITS-1:0]  m;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/core/qmn_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion multiply and normalise channels
// Valid/ready channels for the operand beat and the result beat.
// ----------------------------------------------------------------------------
interface qmn_in_if #(
  parameter int COMP_WIDTH = qmn_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COMP_WIDTH-1:0] a_w;
  logic signed [COMP_WIDTH-1:0] a_x;
  logic signed [COMP_WIDTH-1:0] a_y;
  logic signed [COMP_WIDTH-1:0] a_z;
  logic signed [COMP_WIDTH-1:0] b_w;
  logic signed [COMP_WIDTH-1:0] b_x;
  logic signed [COMP_WIDTH-1:0] b_y;
  logic signed [COMP_WIDTH-1:0] b_z;

  modport source (output valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink   (input valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

interface qmn_out_if #(
  parameter int COMP_WIDTH = qmn_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] out_w;
  logic signed [COMP_WIDTH-1:0] out_x;
  logic signed [COMP_WIDTH-1:0] out_y;
  logic signed [COMP_WIDTH-1:0] out_z;
  logic                         zero_magnitude;

  modport source (output valid, out_w, out_x, out_y, out_z, zero_magnitude,
                  input ready);
  modport sink   (input valid, out_w, out_x, out_y, out_z, zero_magnitude,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/qmn_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; the remainder and partial root move down the line.
// ----------------------------------------------------------------------------
module qmn_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          vld_in,
  input  wire logic [2*qmn_pkg::NORM_BITS+1:0] s_in,
  input  wire qmn_pkg::side_t                side_in,
  output logic                               vld_out,
  output logic [qmn_pkg::NORM_BITS:0]        root_out,
  output qmn_pkg::side_t                     side_out
);
  localparam int SW    = 2 * qmn_pkg::NORM_BITS + 2;
  localparam int RW    = qmn_pkg::NORM_BITS + 1;
  localparam int STEPS = RW;

  logic [SW-1:0]   rem_r  [STEPS+1];
  logic [RW-1:0]   root_r [STEPS+1];
  qmn_pkg::side_t  side_r [STEPS+1];
  logic            vld_r  [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= s_in;
      root_r[0] <= '0;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    logic [SW+1:0] trial;
    logic [SW+1:0] remx;
    logic          take;
    logic [SW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    assign trial    = ({{(SW+2-RW){1'b0}}, root_r[k]} << (B + 1))
                      + ((SW+2)'(1) << (2 * B));
    assign remx     = {2'b00, rem_r[k]};
    assign take     = remx >= trial;
    assign rem_nxt  = take ? SW'(remx - trial) : rem_r[k];
    assign root_nxt = take ? (root_r[k] | (RW'(1) << B)) : root_r[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign vld_out  = vld_r[STEPS];
  assign root_out = root_r[STEPS];
  assign side_out = side_r[STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/qmn_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Four lanes share one divisor; one quotient bit per stage, restoring form.
// ----------------------------------------------------------------------------
module qmn_div #(
  parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_in,
  input  wire logic [qmn_pkg::NORM_BITS:0]  d_in,
  input  wire qmn_pkg::side_t               side_in,
  output logic                              vld_out,
  output logic [3:0][FRAC_BITS:0]           q_out,
  output qmn_pkg::side_t                    side_out
);
  localparam int NB    = qmn_pkg::NORM_BITS;
  localparam int RW    = NB + 1;
  localparam int NW    = NB + FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int STEPS = QW;

  logic [3:0][NW-1:0] rem_r  [STEPS+1];
  logic [3:0][QW-1:0] q_r    [STEPS+1];
  logic [RW-1:0]      d_r    [STEPS+1];
  qmn_pkg::side_t     side_r [STEPS+1];
  logic               vld_r  [STEPS+1];

  logic [3:0][NW-1:0] num_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num_nxt[l] = (NW'(side_in.m[l]) << FRAC_BITS) + NW'(d_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_nxt;
      q_r[0]    <= '0;
      d_r[0]    <= d_in;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    logic [NW-1:0]      dsh;
    logic [3:0][NW-1:0] rem_nxt;
    logic [3:0][QW-1:0] q_nxt;

    assign dsh = NW'(d_r[k]) << B;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (rem_r[k][l] >= dsh) begin
          rem_nxt[l] = rem_r[k][l] - dsh;
          q_nxt[l]   = q_r[k][l] | (QW'(1) << B);
        end else begin
          rem_nxt[l] = rem_r[k][l];
          q_nxt[l]   = q_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        q_r[k+1]    <= q_nxt;
        d_r[k+1]    <= d_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign vld_out  = vld_r[STEPS];
  assign q_out    = q_r[STEPS];
  assign side_out = side_r[STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/quaternion_multiply_normalize_top.sv -----
`default_nettype none
// Throughput: one beat per cycle; the square root takes one stage per root bit
// and the divider one stage per quotient bit, and the whole line advances
// whenever the output register is empty or being taken.
// Reset: synchronous, active low, clears every valid bit; data registers keep their contents.
// ----------------------------------------------------------------------------
// Quaternion multiply and normalise, top level
// Hamilton product or pass-through, block scaling, root and rounded division.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_top #(
  parameter int FRAC_BITS  = qmn_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = qmn_pkg::COMP_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qmn_in_if.sink     in_ch,
  qmn_out_if.source  out_ch
);
  localparam int CW = COMP_WIDTH;
  localparam int NB = qmn_pkg::NORM_BITS;
  localparam int PW = 2 * CW + 2;
  localparam int XW = (PW > NB) ? PW : NB;
  localparam int LW = $clog2(XW + 1);
  localparam int QW = FRAC_BITS + 1;
  localparam int XQ = ((QW > CW) ? QW : CW) + 1;
  localparam int SW = 2 * NB + 2;

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Operand register.
  logic                 vld_a_r;
  logic                 op_a_r;
  logic signed [CW-1:0] a_r [4];
  logic signed [CW-1:0] b_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r <= in_ch.op;
      a_r[0] <= in_ch.a_w;
      a_r[1] <= in_ch.a_x;
      a_r[2] <= in_ch.a_y;
      a_r[3] <= in_ch.a_z;
      b_r[0] <= in_ch.b_w;
      b_r[1] <= in_ch.b_x;
      b_r[2] <= in_ch.b_y;
      b_r[3] <= in_ch.b_z;
    end
  end

  // Products.
  logic                   vld_b_r;
  logic                   op_b_r;
  logic signed [CW-1:0]   a_b_r  [4];
  logic signed [2*CW-1:0] prod_r [4][4];
  logic signed [2*CW-1:0] prod_nxt [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int t = 0; t < 4; t++) begin
        prod_nxt[i][t] = a_r[qmn_pkg::PROD_A[i][t]] * b_r[qmn_pkg::PROD_B[i][t]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_b_r <= op_a_r;
      a_b_r  <= a_r;
      prod_r <= prod_nxt;
    end
  end

  // Sums, sign and magnitude.
  logic          vld_c_r;
  logic [3:0]    neg_c_r;
  logic [PW-1:0] mag_c_r [4];
  logic [3:0]    neg_c_nxt;
  logic [PW-1:0] mag_c_nxt [4];

  always_comb begin
    logic signed [PW-1:0] acc;
    for (int i = 0; i < 4; i++) begin
      if (op_b_r == qmn_pkg::OP_NORM_A) begin
        acc = PW'(a_b_r[i]);
      end else begin
        acc = '0;
        for (int t = 0; t < 4; t++) begin
          if (qmn_pkg::PROD_SUB[i][t]) begin
            acc = acc - PW'(prod_r[i][t]);
          end else begin
            acc = acc + PW'(prod_r[i][t]);
          end
        end
      end
      neg_c_nxt[i] = acc[PW-1];
      mag_c_nxt[i] = acc[PW-1] ? PW'(-acc) : PW'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c_r <= neg_c_nxt;
      mag_c_r <= mag_c_nxt;
    end
  end

  // Bit length of the largest magnitude.
  logic          vld_d_r;
  logic [3:0]    neg_d_r;
  logic [PW-1:0] mag_d_r [4];
  logic [LW-1:0] len_d_r;
  logic [LW-1:0] len_nxt;

  always_comb begin
    logic [PW-1:0] orv;
    orv     = mag_c_r[0] | mag_c_r[1] | mag_c_r[2] | mag_c_r[3];
    len_nxt = '0;
    for (int k = 0; k < PW; k++) begin
      if (orv[k]) begin
        len_nxt = LW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_d_r <= neg_c_r;
      mag_d_r <= mag_c_r;
      len_d_r <= len_nxt;
    end
  end

  // Block scaling.
  logic           vld_e_r;
  qmn_pkg::side_t side_e_r;
  qmn_pkg::side_t side_e_nxt;

  always_comb begin
    logic [XW-1:0] ext;
    side_e_nxt.zero = (len_d_r == '0);
    side_e_nxt.neg  = neg_d_r;
    for (int i = 0; i < 4; i++) begin
      ext = XW'(mag_d_r[i]);
      if (len_d_r > LW'(NB)) begin
        ext = ext >> (len_d_r - LW'(NB));
      end else begin
        ext = ext << (LW'(NB) - len_d_r);
      end
      side_e_nxt.m[i] = ext[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_e_r <= side_e_nxt;
    end
  end

  // Squares.
  logic            vld_f_r;
  qmn_pkg::side_t  side_f_r;
  logic [2*NB-1:0] sq_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
    end else if (en) begin
      vld_f_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_f_r <= side_e_r;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= side_e_r.m[i] * side_e_r.m[i];
      end
    end
  end

  logic [SW-1:0] sumsq;
  assign sumsq = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);

  logic           vld_s;
  logic [NB:0]    root;
  qmn_pkg::side_t side_s;

  qmn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (vld_f_r),
    .s_in     (sumsq),
    .side_in  (side_f_r),
    .vld_out  (vld_s),
    .root_out (root),
    .side_out (side_s)
  );

  logic              vld_q;
  logic [3:0][QW-1:0] quo;
  qmn_pkg::side_t    side_q;

  qmn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (vld_s),
    .d_in     (root),
    .side_in  (side_s),
    .vld_out  (vld_q),
    .q_out    (quo),
    .side_out (side_q)
  );

  // Saturation, sign and output register.
  logic          out_valid_r;
  logic [CW-1:0] res_r [4];
  logic          zero_r;
  logic [CW-1:0] res_nxt [4];

  always_comb begin
    logic [XQ-1:0] qx;
    logic [XQ-1:0] limx;
    logic [XQ-1:0] sat;
    logic [XQ-1:0] val;
    for (int i = 0; i < 4; i++) begin
      qx   = XQ'(quo[i]);
      limx = (XQ'(1) << (CW - 1)) - XQ'(!side_q.neg[i]);
      sat  = (qx > limx) ? limx : qx;
      val  = side_q.neg[i] ? (~sat + XQ'(1)) : sat;
      res_nxt[i] = side_q.zero ? '0 : val[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      zero_r <= side_q.zero;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_w          = res_r[0];
  assign out_ch.out_x          = res_r[1];
  assign out_ch.out_y          = res_r[2];
  assign out_ch.out_z          = res_r[3];
  assign out_ch.zero_magnitude = zero_r;

  a_zero_forces_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> (res_r[0] == '0) && (res_r[1] == '0)
                              && (res_r[2] == '0) && (res_r[3] == '0))
    else $error("zero magnitude result carries non-zero components");

  a_nonzero_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !zero_r |-> (res_r[0] != '0) || (res_r[1] != '0)
                               || (res_r[2] != '0) || (res_r[3] != '0))
    else $error("normalised result lost every component");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !vld_a_r)
    else $error("pipeline holds a beat after reset");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(zero_r))
    else $error("stalled result changed");

endmodule
`default_nettype wire
